>>> sv/stac_pkg.sv
// ----------------------------------------------------------------------------
// stac_pkg
// Types, codes and constants for the saturating time value arithmetic block.
// ----------------------------------------------------------------------------
package stac_pkg;

    localparam int ONE_SECOND_USEC = 1000000;

    localparam logic [19:0] USEC_MAX = 20'd999999;
    localparam logic [63:0] SEC_MAX  = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] SEC_MIN  = 64'h8000_0000_0000_0000;

    localparam logic [1:0] OP_SUM  = 2'd0;
    localparam logic [1:0] OP_DIFF = 2'd1;
    localparam logic [1:0] OP_CMP  = 2'd2;
    localparam logic [1:0] OP_NORM = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_POS_SAT = 2'd1;
    localparam logic [1:0] ST_NEG_SAT = 2'd2;

    localparam logic [1:0] ORD_EARLIER = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_LATER   = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [63:0] a_sec;
        logic signed [63:0] a_usec;
        logic signed [63:0] b_sec;
        logic [19:0]        b_usec;
    } in_t;

    typedef struct packed {
        logic signed [63:0] res_sec;
        logic [19:0]        res_usec;
        logic [1:0]         status;
        logic [1:0]         order;
    } out_t;

endpackage

>>> sv/saturating_timeval_arithmetic_top.sv
// ----------------------------------------------------------------------------
// saturating_timeval_arithmetic_top
// Pipelined sum, difference, compare and normalize on (sec, usec) time values.
// ----------------------------------------------------------------------------
// Takes one beat per clock while the output side keeps up and returns one result
// beat per input beat, in order. Most of the stages serve the floor
// division of the 64-bit microsecond count by one million: the count is split
// into sign and magnitude, the six low bits go straight into the remainder and
// the rest is divided by 15625 in four 16-bit digits, each taking an estimate
// stage (reciprocal multiply) and a reduction stage. Preparation, two
// finishing stages and the output register make up the rest. A stall on the
// output holds every stage that cannot move on, while bubbles upstream still
// fill.
// ----------------------------------------------------------------------------
module saturating_timeval_arithmetic_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  stac_pkg::in_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output stac_pkg::out_t out_data
);
    import stac_pkg::*;

    localparam int DIGITS         = 4;
    localparam int DIV_STAGES     = 2 * DIGITS;
    localparam int FIN1           = DIV_STAGES + 1;
    localparam int FIN2           = DIV_STAGES + 2;
    localparam int OUTS           = DIV_STAGES + 3;
    localparam int STAGES         = DIV_STAGES + 4;

    localparam logic [21:0] MILLION_22 = 22'(ONE_SECOND_USEC);
    localparam logic [21:0] TWO_MILLION_22 = 22'(2 * ONE_SECOND_USEC);

    // one million is 64 * 15625
    localparam logic [13:0] DIV_ODD   = 14'(ONE_SECOND_USEC / 64);
    // ceil(2^44 / 15625): exact floor quotient for any 30-bit numerator
    localparam logic [30:0] DIV_RECIP = 31'd1125899907;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  order;
        logic        neg;
        logic [65:0] sec_sum;
        logic [63:0] num;
        logic [5:0]  low;
        logic [63:0] quo;
        logic [13:0] rem;
        logic [29:0] part;
        logic [15:0] digit;
        logic [19:0] b_usec;
    } pipe_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  order;
        logic [65:0] sec_sum;
        logic [63:0] q1;
        logic [21:0] r1;
    } fin1_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  order;
        logic [66:0] total;
        logic [19:0] r;
    } fin2_t;

    function automatic pipe_t div_estimate(pipe_t d);
        pipe_t       o;
        logic [60:0] prod;
        o       = d;
        o.part  = {d.rem, d.num[63:48]};
        prod    = {31'd0, o.part} * {30'd0, DIV_RECIP};
        o.digit = prod[59:44];
        return o;
    endfunction

    function automatic pipe_t div_reduce(pipe_t d);
        pipe_t       o;
        logic [29:0] back;
        logic [29:0] left;
        o     = d;
        back  = {14'd0, d.digit} * {16'd0, DIV_ODD};
        left  = d.part - back;
        o.rem = left[13:0];
        o.quo = {d.quo[47:0], d.digit};
        o.num = {d.num[47:0], 16'd0};
        return o;
    endfunction

    logic [STAGES-1:0] vld_reg;
    logic [STAGES:0]   adv;

    pipe_t pipe_reg  [0:DIV_STAGES];
    pipe_t pipe_next [0:DIV_STAGES];
    fin1_t fin1_reg, fin1_next;
    fin2_t fin2_reg, fin2_next;
    out_t  out_reg,  out_next;

    always_comb
    begin
        adv[STAGES] = out_ready;
        for (int s = STAGES - 1; s >= 0; s--)
        begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[OUTS];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s < STAGES; s++)
            begin
                if (adv[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // preparation: seconds sum, sign split of usec, comparison
    always_comb
    begin
        logic [65:0] a66;
        logic [65:0] b66;
        logic [63:0] mag;
        a66 = {{2{in_data.a_sec[63]}}, in_data.a_sec};
        b66 = {{2{in_data.b_sec[63]}}, in_data.b_sec};
        mag = in_data.a_usec[63] ? ~in_data.a_usec : in_data.a_usec;
        pipe_next[0].op     = in_data.operation;
        pipe_next[0].neg    = in_data.a_usec[63];
        pipe_next[0].num    = {6'd0, mag[63:6]};
        pipe_next[0].low    = mag[5:0];
        pipe_next[0].quo    = '0;
        pipe_next[0].rem    = '0;
        pipe_next[0].part   = '0;
        pipe_next[0].digit  = '0;
        pipe_next[0].b_usec = in_data.b_usec;
        unique case (in_data.operation)
            OP_SUM:  pipe_next[0].sec_sum = a66 + b66;
            OP_DIFF: pipe_next[0].sec_sum = a66 - b66;
            default: pipe_next[0].sec_sum = a66;
        endcase
        priority if (in_data.a_sec < in_data.b_sec)
            pipe_next[0].order = ORD_EARLIER;
        else if (in_data.a_sec > in_data.b_sec)
            pipe_next[0].order = ORD_LATER;
        else if (in_data.a_usec < $signed({44'd0, in_data.b_usec}))
            pipe_next[0].order = ORD_EARLIER;
        else if (in_data.a_usec > $signed({44'd0, in_data.b_usec}))
            pipe_next[0].order = ORD_LATER;
        else
            pipe_next[0].order = ORD_EQUAL;
    end

    for (genvar k = 1; k <= DIV_STAGES; k++)
    begin : g_div
        if (k % 2 == 1)
        begin : g_est
            assign pipe_next[k] = div_estimate(pipe_reg[k-1]);
        end
        else
        begin : g_red
            assign pipe_next[k] = div_reduce(pipe_reg[k-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= DIV_STAGES; k++)
        begin
            if (adv[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
        if (adv[FIN1])
        begin
            fin1_reg <= fin1_next;
        end
        if (adv[FIN2])
        begin
            fin2_reg <= fin2_next;
        end
        if (adv[OUTS])
        begin
            out_reg <= out_next;
        end
    end

    // floor quotient and remainder, then fold in b_usec for sum and difference
    always_comb
    begin
        pipe_t       p;
        logic [19:0] rx;
        logic [21:0] r0;
        p  = pipe_reg[DIV_STAGES];
        rx = {p.rem, p.low};
        r0 = {2'b00, p.neg ? USEC_MAX - rx : rx};
        fin1_next.op      = p.op;
        fin1_next.order   = p.order;
        fin1_next.sec_sum = p.sec_sum;
        fin1_next.q1      = p.neg ? ~p.quo : p.quo;
        unique case (p.op)
            OP_SUM:  fin1_next.r1 = r0 + {2'b00, p.b_usec};
            OP_DIFF: fin1_next.r1 = r0 - {2'b00, p.b_usec};
            default: fin1_next.r1 = r0;
        endcase
    end

    // second carry and full seconds total
    always_comb
    begin
        logic [2:0]  q2;
        logic [21:0] off;
        priority if ($signed(fin1_reg.r1) < -$signed(MILLION_22))
        begin
            q2  = 3'b110;
            off = TWO_MILLION_22;
        end
        else if ($signed(fin1_reg.r1) < 0)
        begin
            q2  = 3'b111;
            off = MILLION_22;
        end
        else if ($signed(fin1_reg.r1) >= $signed(TWO_MILLION_22))
        begin
            q2  = 3'b010;
            off = -TWO_MILLION_22;
        end
        else if ($signed(fin1_reg.r1) >= $signed(MILLION_22))
        begin
            q2  = 3'b001;
            off = -MILLION_22;
        end
        else
        begin
            q2  = 3'b000;
            off = '0;
        end
        fin2_next.op    = fin1_reg.op;
        fin2_next.order = fin1_reg.order;
        fin2_next.r     = 20'(fin1_reg.r1 + off);
        fin2_next.total = {fin1_reg.sec_sum[65], fin1_reg.sec_sum}
                        + {{3{fin1_reg.q1[63]}}, fin1_reg.q1}
                        + {{64{q2[2]}}, q2};
    end

    // saturation and result formatting
    always_comb
    begin
        out_next = '0;
        if (fin2_reg.op == OP_CMP)
        begin
            out_next.order = fin2_reg.order;
        end
        else if (fin2_reg.total[66:63] == 4'b0000 || fin2_reg.total[66:63] == 4'b1111)
        begin
            out_next.res_sec  = fin2_reg.total[63:0];
            out_next.res_usec = fin2_reg.r;
            out_next.status   = ST_OK;
        end
        else if (fin2_reg.total[66])
        begin
            out_next.res_sec  = SEC_MIN;
            out_next.res_usec = '0;
            out_next.status   = ST_NEG_SAT;
        end
        else
        begin
            out_next.res_sec  = SEC_MAX;
            out_next.res_usec = USEC_MAX;
            out_next.status   = ST_POS_SAT;
        end
    end

endmodule

>>> sv/stac_checker.sv
// ----------------------------------------------------------------------------
// stac_checker
// Port-level checks on the result channel of the time value arithmetic block.
// ----------------------------------------------------------------------------
module stac_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           out_valid,
    input logic           out_ready,
    input stac_pkg::out_t out_data
);
    import stac_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");

    a_usec_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.res_usec <= USEC_MAX)
        else $error("usec out of range");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (out_data.status != ST_POS_SAT
                || (out_data.res_sec == SEC_MAX && out_data.res_usec == USEC_MAX))
            && (out_data.status != ST_NEG_SAT
                || (out_data.res_sec == SEC_MIN && out_data.res_usec == 20'd0)))
        else $error("saturated result inconsistent with status");

    a_compare_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.order != ORD_EARLIER |->
            out_data.res_sec == 64'sd0 && out_data.res_usec == 20'd0
            && out_data.status == ST_OK)
        else $error("compare beat carries a time value");

endmodule

bind saturating_timeval_arithmetic_top stac_checker u_stac_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/sv/saturating_timeval_arithmetic_top_tb.sv
// ----------------------------------------------------------------------------
// saturating_timeval_arithmetic_top_tb
// Self-checking bench for the saturating time value arithmetic block.
// ----------------------------------------------------------------------------
// A directed set covers the saturation edges, microsecond borrow and carry,
// unnormalised inputs and every compare outcome. Random beats follow, with
// seconds near the limits and full-range microseconds. Both handshakes see
// random gaps and stalls. Every input beat is predicted with exact 128-bit
// arithmetic. Each output beat is checked, field by field, against the oldest
// prediction.
// ----------------------------------------------------------------------------
module saturating_timeval_arithmetic_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import stac_pkg::*;

    class timeval_checker;
        out_t        pending_results[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
        endfunction

        function out_t timeval_outcome(in_t d);
            logic signed [127:0] secs;
            logic signed [127:0] usecs;
            logic signed [127:0] carry;
            logic signed [127:0] rem;
            logic signed [127:0] divisor;
            out_t                r;
            r       = '0;
            divisor = ONE_SECOND_USEC;
            usecs   = $signed(d.a_usec);
            secs    = $signed(d.a_sec);
            if (d.operation == OP_CMP)
            begin
                rem = {108'd0, d.b_usec};
                if ($signed(d.a_sec) < $signed(d.b_sec))
                    r.order = ORD_EARLIER;
                else if ($signed(d.a_sec) > $signed(d.b_sec))
                    r.order = ORD_LATER;
                else if (usecs < rem)
                    r.order = ORD_EARLIER;
                else if (usecs > rem)
                    r.order = ORD_LATER;
                else
                    r.order = ORD_EQUAL;
            end
            else
            begin
                if (d.operation == OP_SUM)
                begin
                    secs  = secs + $signed(d.b_sec);
                    usecs = usecs + {108'd0, d.b_usec};
                end
                else if (d.operation == OP_DIFF)
                begin
                    secs  = secs - $signed(d.b_sec);
                    usecs = usecs - {108'd0, d.b_usec};
                end
                // floor division
                carry = usecs / divisor;
                rem   = usecs % divisor;
                if (rem < 0)
                begin
                    carry = carry - 1;
                    rem   = rem + divisor;
                end
                secs = secs + carry;
                if (secs[127:63] == '0 || secs[127:63] == '1)
                begin
                    r.res_sec  = secs[63:0];
                    r.res_usec = rem[19:0];
                    r.status   = ST_OK;
                end
                else if (secs[127])
                begin
                    r.res_sec  = SEC_MIN;
                    r.res_usec = '0;
                    r.status   = ST_NEG_SAT;
                end
                else
                begin
                    r.res_sec  = SEC_MAX;
                    r.res_usec = USEC_MAX;
                    r.status   = ST_POS_SAT;
                end
            end
            return r;
        endfunction

        function void note_input(in_t d);
            pending_results.push_back(timeval_outcome(d));
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns %s: got %0h, expected %0h", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0)
                report("result beat with nothing pending", got.res_sec, '0);
            else
            begin
                want = pending_results.pop_front();
                if (got.res_sec !== want.res_sec)
                    report("res_sec", got.res_sec, want.res_sec);
                if (got.res_usec !== want.res_usec)
                    report("res_usec", 64'(got.res_usec), 64'(want.res_usec));
                if (got.status !== want.status)
                    report("status", 64'(got.status), 64'(want.status));
                if (got.order !== want.order)
                    report("order", 64'(got.order), 64'(want.order));
            end
        endtask
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    timeval_checker sb = new();
    bit             calm = 1'b0;

    saturating_timeval_arithmetic_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_input(in_data);
        if (rst_n && out_valid && out_ready)
            sb.check_result(out_data);
    end

    function automatic in_t beat(logic [1:0] op, logic [63:0] as, logic [63:0] au,
                                 logic [63:0] bs, logic [19:0] bu);
        in_t d;
        d.operation = op;
        d.a_sec     = as;
        d.a_usec    = au;
        d.b_sec     = bs;
        d.b_usec    = bu;
        return d;
    endfunction

    function automatic logic [63:0] random_seconds();
        longint v;
        case ($urandom_range(0, 3))
            0: v = longint'(SEC_MAX) - longint'($urandom_range(0, 3));
            1: v = longint'(SEC_MIN) + longint'($urandom_range(0, 3));
            2: v = longint'($urandom_range(0, 2000)) - 1000;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_beat(input in_t d);
        int unsigned gap;
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!in_ready);
        if (calm || $urandom_range(0, 9) < 7)
            gap = 0;
        else if ($urandom_range(0, 5) != 0)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.outstanding() != 0);
    endtask

    // result side: ready runs and stalls of random length
    initial
    begin : sink
        int unsigned hold;
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 8);
            repeat (hold) @(posedge clk);
            case ($urandom_range(0, 9))
                0:       stall = $urandom_range(15, 60);
                1, 2, 3: stall = $urandom_range(3, 6);
                default: stall = $urandom_range(1, 2);
            endcase
            out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        in_t    d;
        longint v;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_beat(beat(OP_SUM, 64'd0, 64'd0, 64'd0, 20'd0));
        send_beat(beat(OP_SUM, SEC_MAX, 64'd500000, 64'd0, 20'd499999));
        send_beat(beat(OP_SUM, SEC_MAX, 64'd999999, 64'd0, 20'd1));
        send_beat(beat(OP_SUM, SEC_MAX, 64'd0, SEC_MAX, 20'd0));
        send_beat(beat(OP_SUM, SEC_MIN, 64'd0, SEC_MIN, 20'd0));
        send_beat(beat(OP_SUM, 64'd5, 64'd999999, 64'd7, 20'hfffff));
        send_beat(beat(OP_SUM, 64'd1, -64'sd1, 64'd2, 20'd0));
        send_beat(beat(OP_DIFF, SEC_MIN, 64'd0, 64'd0, 20'd1));
        send_beat(beat(OP_DIFF, SEC_MIN, 64'd0, 64'd1, 20'd0));
        send_beat(beat(OP_DIFF, 64'd0, 64'd0, SEC_MIN, 20'd0));
        send_beat(beat(OP_DIFF, SEC_MAX, 64'd999999, SEC_MIN, 20'd0));
        send_beat(beat(OP_DIFF, 64'd0, 64'd0, 64'd0, 20'hfffff));
        send_beat(beat(OP_DIFF, -64'sd1, 64'd999999, -64'sd1, 20'd999999));
        send_beat(beat(OP_DIFF, SEC_MIN, 64'd999999, -64'sd1, 20'd0));
        send_beat(beat(OP_NORM, SEC_MIN, -64'sd1, 64'd0, 20'd0));
        send_beat(beat(OP_NORM, SEC_MAX, 64'd1000000, 64'd0, 20'd0));
        send_beat(beat(OP_NORM, 64'd0, SEC_MIN, 64'd0, 20'd0));
        send_beat(beat(OP_NORM, 64'd0, SEC_MAX, 64'd0, 20'd0));
        send_beat(beat(OP_NORM, SEC_MIN, SEC_MAX, 64'd0, 20'd0));
        send_beat(beat(OP_NORM, SEC_MAX, SEC_MIN, 64'd0, 20'd0));
        send_beat(beat(OP_NORM, 64'd3, -64'sd1000000, -64'sd1, 20'hfffff));
        send_beat(beat(OP_CMP, SEC_MIN, 64'd0, SEC_MAX, 20'd0));
        send_beat(beat(OP_CMP, 64'd7, 64'd5, 64'd7, 20'd5));
        send_beat(beat(OP_CMP, 64'd7, -64'sd1, 64'd7, 20'd0));
        send_beat(beat(OP_CMP, 64'd7, SEC_MAX, 64'd7, 20'hfffff));
        send_beat(beat(OP_CMP, SEC_MAX, 64'd0, SEC_MIN, 20'd0));
        drain();

        for (int i = 0; i < 500; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            d.operation = 2'($urandom_range(0, 3));
            d.a_sec     = random_seconds();
            d.b_sec     = random_seconds();
            if (d.operation == OP_NORM || $urandom_range(0, 7) == 0)
            begin
                case ($urandom_range(0, 2))
                    0: v = {$urandom, $urandom};
                    1: v = longint'($urandom_range(0, 6000000)) - 3000000;
                    default: v = ($urandom_range(0, 1) != 0)
                                 ? longint'(SEC_MAX) - longint'($urandom_range(0, 999))
                                 : longint'(SEC_MIN) + longint'($urandom_range(0, 999));
                endcase
                d.a_usec = v;
            end
            else
                d.a_usec = 64'($urandom_range(0, 999999));
            d.b_usec = ($urandom_range(0, 7) == 0) ? 20'($urandom)
                                                   : 20'($urandom_range(0, 999999));
            if (d.operation == OP_CMP && $urandom_range(0, 2) == 0)
            begin
                d.b_sec = d.a_sec;
                if ($urandom_range(0, 1) != 0)
                    d.b_usec = d.a_usec[19:0];
            end
            send_beat(d);
            if (i == 250)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("saturating_timeval_arithmetic_top: match");
        else
            $display("saturating_timeval_arithmetic_top: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #2ms;
        $display("saturating_timeval_arithmetic_top: mismatch");
        $finish;
    end

endmodule

>>> sim.f
sv/stac_pkg.sv
sv/saturating_timeval_arithmetic_top.sv
sv/stac_checker.sv
tb/sv/saturating_timeval_arithmetic_top_tb.sv
